// ----- rtl/core/exposure_search_controller_defines.svh -----
// Assertion macros shared by the exposure search controller RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef EXPOSURE_SEARCH_CONTROLLER_DEFINES_SVH
`define EXPOSURE_SEARCH_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent checked in the same cycle as the antecedent.
`define ESC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent checked in the cycle after the antecedent.
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ESC_ASSERT_SAME(label, ante, cons, msg)
`define ESC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- rtl/core/esc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exposure search controller package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package esc_pkg;

  localparam int FRACTION_BITS_DEF = 8;

  localparam int GRAY_W      = 16;
  localparam int GAIN_W      = 12;
  localparam int EXPO_W      = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int DIFF_W      = GRAY_W + 1;
  // Error plus one unit stays below 2^17 for up to 12 fraction bits.
  localparam int BEST_W      = 17;
  localparam int STEP_W      = DIFF_W + GAIN_W + 1;

  localparam logic [GRAY_W-1:0] TARGET_GRAY_RST      = 16'd46502;
  localparam logic [GRAY_W-1:0] SETTLE_THRESHOLD_RST = 16'd768;
  localparam logic [GAIN_W-1:0] STEP_GAIN_RST        = 12'd230;
  localparam logic [EXPO_W-1:0] INITIAL_EXPOSURE_RST = 16'd30963;
  localparam logic [EXPO_W-1:0] EXPOSURE_LIMIT_RST   = 16'd60000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET_GRAY      = 3'd0,
    REG_SETTLE_THRESHOLD = 3'd1,
    REG_STEP_GAIN        = 3'd2,
    REG_INITIAL_EXPOSURE = 3'd3,
    REG_EXPOSURE_LIMIT   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SEARCH,
    ST_OUT
  } esc_state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic halve;
    logic commit;
    logic emit;
  } esc_cmd_t;

  typedef struct packed {
    logic settled;
    logic need_halve;
  } esc_status_t;

endpackage

// ----- rtl/core/esc_stream_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exposure search controller stream interfaces
// Valid/ready channels for measurement words and exposure result words.
// ----------------------------------------------------------------------------
interface esc_in_if
  import esc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] measured_gray;
  logic              run_start;

  modport source (output valid, output measured_gray, output run_start, input ready);
  modport sink   (input valid, input measured_gray, input run_start, output ready);
endinterface

interface esc_out_if
  import esc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [EXPO_W-1:0] exposure_us;
  logic              settled;

  modport source (output valid, output exposure_us, output settled, input ready);
  modport sink   (input valid, input exposure_us, input settled, output ready);
endinterface

// ----- rtl/core/exposure_search_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exposure search controller
// Steps an exposure search from measured frame brightness, one word at a time.
// ----------------------------------------------------------------------------
// An accepted word is loaded, evaluated and then committed after any extra step
// halvings, one per cycle in the datapath, before its result is emitted.
// Words are taken one at a time; emit waits while a prior result is not taken.
// Reset (synchronous, rst_n low) restores register defaults and clears the
// run, so the first word afterwards restarts from the initial exposure.
// ----------------------------------------------------------------------------
module exposure_search_controller
  import esc_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  esc_in_if.sink                 in_stream,
  esc_out_if.source              out_stream,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  esc_cmd_t    cmd;
  esc_status_t status;

  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_stream.valid),
    .in_ready  (in_stream.ready),
    .out_valid (out_stream.valid),
    .out_ready (out_stream.ready),
    .status    (status),
    .cmd       (cmd)
  );

  esc_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_gray         (in_stream.measured_gray),
    .in_run_start    (in_stream.run_start),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_exposure_us (out_stream.exposure_us),
    .out_settled     (out_stream.settled)
  );

endmodule

// ----- rtl/core/esc_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exposure search datapath
// Configuration registers, search state, step multiplier and halving unit.
// ----------------------------------------------------------------------------
`include "exposure_search_controller_defines.svh"

module esc_datapath
  import esc_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  esc_cmd_t               cmd,
  output esc_status_t            status,
  input  logic [GRAY_W-1:0]      in_gray,
  input  logic                   in_run_start,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [EXPO_W-1:0]      out_exposure_us,
  output logic                   out_settled
);

  localparam int EXP_W = EXPO_W + FRACTION_BITS;
  localparam int SUM_W = ((EXP_W + 1 > STEP_W) ? EXP_W + 1 : STEP_W) + 1;

  // Configuration registers
  logic [GRAY_W-1:0] target_r;
  logic [GRAY_W-1:0] thr_r;
  logic [GAIN_W-1:0] gain_r;
  logic [EXPO_W-1:0] init_r;
  logic [EXPO_W-1:0] limit_r;

  // Search state
  logic signed [DIFF_W-1:0] diff_r;
  logic                     restart_r;
  logic                     run_active_r;
  logic [EXP_W-1:0]         base_r;
  logic [EXP_W-1:0]         cur_r;
  logic [BEST_W-1:0]        best_r;
  logic signed [STEP_W-1:0] step_r;
  logic                     settled_r;
  logic [EXPO_W-1:0]        out_exp_r;
  logic                     out_set_r;

  logic [EXP_W-1:0]         init_fx;
  logic [EXP_W-1:0]         upper_fx;
  logic signed [DIFF_W-1:0] diff_neg;
  logic [GRAY_W-1:0]        err;
  logic                     start;
  logic [EXP_W-1:0]         base_eff;
  logic [EXP_W-1:0]         cur_eff;
  logic [BEST_W-1:0]        best_eff;
  logic signed [STEP_W-1:0] step_eff;
  logic                     settle_now;
  logic                     improved;
  logic signed [STEP_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  upper_s;

  function automatic logic signed [STEP_W-1:0] halve_step(input logic signed [STEP_W-1:0] v);
    logic signed [STEP_W-1:0] t;
    // Adding the sign bit first makes the arithmetic shift round toward zero.
    t = v + $signed({{(STEP_W-1){1'b0}}, v[STEP_W-1]});
    return t >>> 1;
  endfunction

  assign init_fx  = EXP_W'(init_r) << FRACTION_BITS;
  assign upper_fx = EXP_W'(limit_r) << FRACTION_BITS;
  assign diff_neg = -diff_r;
  assign err      = diff_r[DIFF_W-1] ? diff_neg[GRAY_W-1:0] : diff_r[GRAY_W-1:0];
  assign start    = restart_r || !run_active_r;

  assign base_eff = start ? init_fx : base_r;
  assign cur_eff  = start ? init_fx : cur_r;
  assign best_eff = start ? BEST_W'(err) + (BEST_W'(1) << FRACTION_BITS) : best_r;
  assign step_eff = start ? (STEP_W'(1) << FRACTION_BITS) : step_r;

  assign settle_now = (err <= thr_r);
  assign improved   = (BEST_W'(err) < best_eff);
  assign prod       = STEP_W'(diff_r) * STEP_W'($signed({1'b0, gain_r}));

  assign sum     = $signed({{(SUM_W-EXP_W){1'b0}}, base_r}) + SUM_W'(step_r);
  assign upper_s = $signed({{(SUM_W-EXP_W){1'b0}}, upper_fx});

  assign status.settled    = settled_r;
  assign status.need_halve = (step_r != '0) &&
                             (sum[SUM_W-1] || (sum == '0) || (sum >= upper_s));

  assign out_exposure_us = out_exp_r;
  assign out_settled     = out_set_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_GRAY_RST;
      thr_r    <= SETTLE_THRESHOLD_RST;
      gain_r   <= STEP_GAIN_RST;
      init_r   <= INITIAL_EXPOSURE_RST;
      limit_r  <= EXPOSURE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TARGET_GRAY:      target_r <= cfg_data[GRAY_W-1:0];
        REG_SETTLE_THRESHOLD: thr_r    <= cfg_data[GRAY_W-1:0];
        REG_STEP_GAIN:        gain_r   <= cfg_data[GAIN_W-1:0];
        REG_INITIAL_EXPOSURE: init_r   <= cfg_data[EXPO_W-1:0];
        REG_EXPOSURE_LIMIT:   limit_r  <= cfg_data[EXPO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r <= 1'b0;
    end else if (cmd.eval && start) begin
      run_active_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      diff_r    <= $signed({1'b0, target_r}) - $signed({1'b0, in_gray});
      restart_r <= in_run_start;
    end
    if (cmd.eval) begin
      settled_r <= settle_now;
      cur_r     <= cur_eff;
      if (!settle_now && improved) begin
        base_r <= cur_eff;
        best_r <= BEST_W'(err);
        step_r <= prod;
      end else if (!settle_now) begin
        base_r <= base_eff;
        best_r <= best_eff;
        step_r <= halve_step(step_eff);
      end else begin
        base_r <= base_eff;
        best_r <= best_eff;
        step_r <= step_eff;
      end
    end
    if (cmd.halve) begin
      step_r <= halve_step(step_r);
    end
    if (cmd.commit && !settled_r) begin
      cur_r <= sum[EXP_W-1:0];
    end
    if (cmd.emit) begin
      out_exp_r <= cur_r[FRACTION_BITS +: EXPO_W];
      out_set_r <= settled_r;
    end
  end

  `ESC_ASSERT_NEXT(a_restart_base, cmd.eval && start, base_r == $past(init_fx), "base not at initial exposure after run start")
  `ESC_ASSERT_NEXT(a_halve_keeps_base, cmd.halve, (base_r == $past(base_r)) && (cur_r == $past(cur_r)), "halving changed base or current exposure")
  `ESC_ASSERT_NEXT(a_best_no_worse, cmd.eval && !settle_now, best_r <= $past(best_eff), "best error grew during evaluation")

endmodule

// ----- rtl/core/esc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exposure search controller sequencer
// Steps one measurement word through evaluation, step halving and output.
// ----------------------------------------------------------------------------
`include "exposure_search_controller_defines.svh"

module esc_ctrl
  import esc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  esc_status_t status,
  output esc_cmd_t    cmd
);

  esc_state_t state_r;
  esc_state_t state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        // One halving per cycle until base plus step lands inside the range or the step is zero; none once settled.
        if (status.need_halve && !status.settled) begin
          cmd.halve = 1'b1;
        end else begin
          cmd.commit = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `ESC_ASSERT_NEXT(a_accept_to_eval, in_valid && in_ready, state_r == ST_EVAL, "accepted word did not start evaluation")
  `ESC_ASSERT_NEXT(a_emit_shows_word, cmd.emit, out_valid_r && (state_r == ST_IDLE), "emitted result not presented")
  `ESC_ASSERT_NEXT(a_search_ends, (state_r == ST_SEARCH) && !(status.need_halve && !status.settled), state_r == ST_OUT, "search did not finish when in range")

endmodule
